### hw/rtl/fusc_pkg.sv
package fusc_pkg;

   // Request kinds as decoded by the packet framer.
   localparam logic [3:0] MODE_HELLO   = 4'd0;
   localparam logic [3:0] MODE_BEGIN   = 4'd1;
   localparam logic [3:0] MODE_DATA    = 4'd2;
   localparam logic [3:0] MODE_END     = 4'd3;
   localparam logic [3:0] MODE_INSTALL = 4'd4;
   localparam logic [3:0] MODE_STATUS  = 4'd5;
   localparam logic [3:0] MODE_ABORT   = 4'd6;
   localparam logic [3:0] MODE_REBOOT  = 4'd7;

   localparam logic [3:0] RES_OK              = 4'd0;
   localparam logic [3:0] RES_BAD_LENGTH      = 4'd1;
   localparam logic [3:0] RES_BAD_TARGET      = 4'd2;
   localparam logic [3:0] RES_BAD_SIZE        = 4'd3;
   localparam logic [3:0] RES_ERASE_FAIL      = 4'd4;
   localparam logic [3:0] RES_NOT_STARTED     = 4'd5;
   localparam logic [3:0] RES_WRITE_FAIL      = 4'd6;
   localparam logic [3:0] RES_OFFSET_MISMATCH = 4'd7;
   localparam logic [3:0] RES_CRC_FAIL        = 4'd8;
   localparam logic [3:0] RES_INVALID         = 4'd9;
   localparam logic [3:0] RES_NO_IMAGE        = 4'd10;
   localparam logic [3:0] RES_INSTALL_FAIL    = 4'd11;
   localparam logic [3:0] RES_UNKNOWN         = 4'd12;

   localparam logic [2:0] SESS_IDLE       = 3'd0;
   localparam logic [2:0] SESS_RECV       = 3'd1;
   localparam logic [2:0] SESS_ERROR      = 3'd2;
   localparam logic [2:0] SESS_VERIFIED   = 3'd3;
   localparam logic [2:0] SESS_INSTALLING = 3'd4;
   localparam logic [2:0] SESS_INSTALLED  = 3'd5;

   localparam logic [1:0] CSR_BOARD_MAGIC     = 2'd0;
   localparam logic [1:0] CSR_MAX_BLOCK_BYTES = 2'd1;
   localparam logic [1:0] CSR_MAX_IMAGE_BYTES = 2'd2;
   localparam logic [1:0] CSR_LOADER_VERSION  = 2'd3;

   localparam logic [31:0] BOARD_MAGIC_RESET     = 32'd0;
   localparam logic [15:0] MAX_BLOCK_BYTES_RESET = 16'd1024;
   localparam logic [31:0] MAX_IMAGE_BYTES_RESET = 32'd65536;
   localparam logic [31:0] LOADER_VERSION_RESET  = 32'd0;

   localparam logic [15:0] BEGIN_PAYLOAD    = 16'd16;
   localparam logic [15:0] DATA_MIN_PAYLOAD = 16'd7;
   localparam logic [15:0] DATA_HEADER      = 16'd6;
   localparam logic [1:0]  ALIGN_MASK       = 2'b11;

   typedef struct packed {
      logic [3:0]  mode;
      logic [7:0]  command_byte;
      logic [15:0] sequence_number;
      logic [15:0] payload_bytes;
      logic [31:0] word_a;
      logic [31:0] word_b;
      logic [31:0] word_c;
      logic [31:0] word_d;
      logic        flash_ok;
      logic        check_ok;
      logic [31:0] stored_version;
   } req_type;

   typedef struct packed {
      logic        is_nack;
      logic [15:0] echo_sequence;
      logic [7:0]  echo_command;
      logic [3:0]  result_code;
      logic [2:0]  session_code;
      logic [31:0] reply_value;
      logic [15:0] block_limit;
      logic        reboot_request;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [31:0] image_version;
      logic [31:0] image_length;
      logic [31:0] image_checksum;
      logic [31:0] next_offset;
   } sess_type;

   typedef struct packed {
      logic [31:0] board_magic;
      logic [15:0] max_block_bytes;
      logic [31:0] max_image_bytes;
      logic [31:0] loader_version;
   } cfg_type;

endpackage

### hw/rtl/firmware_update_session_checker_unit.sv
// Firmware update session checker.
// The req_ channel carries one framed, CRC-checked update packet per
// transaction together with the flash outcome flags that belong to it.
// The rsp_ channel returns exactly one reply transaction per request, in
// order. Both channels move a transaction at a clock edge with valid high
// and stall low. The csr_ port writes one of four registers per cycle with
// csr_write; write it only while no request is in flight.
// A request accepted into the request stage passes through the reply stage
// before it is presented on rsp_ (two registers: request stage, reply stage).
// Throughput: one transaction per cycle while the receiver does not stall. The session state is updated as
// a request leaves the request stage, so back-to-back requests each see
// the state left by the one before.
// When the receiver stalls, the reply holds unchanged; the request stage
// still takes one more transaction if it is empty, and then req_stall rises until the
// reply is taken.
// Synchronous reset empties both stages, returns the session to idle with
// all image fields and the expected offset at zero, and restores the
// register defaults.
module firmware_update_session_checker_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_mode,
   input  logic [7:0]  req_command_byte,
   input  logic [15:0] req_sequence_number,
   input  logic [15:0] req_payload_bytes,
   input  logic [31:0] req_word_a,
   input  logic [31:0] req_word_b,
   input  logic [31:0] req_word_c,
   input  logic [31:0] req_word_d,
   input  logic        req_flash_ok,
   input  logic        req_check_ok,
   input  logic [31:0] req_stored_version,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_is_nack,
   output logic [15:0] rsp_echo_sequence,
   output logic [7:0]  rsp_echo_command,
   output logic [3:0]  rsp_result_code,
   output logic [2:0]  rsp_session_code,
   output logic [31:0] rsp_reply_value,
   output logic [15:0] rsp_block_limit,
   output logic        rsp_reboot_request,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import fusc_pkg::*;

   cfg_type  cfg;
   req_type  req_ff;
   logic     req_valid_ff;
   logic     req_valid_in;
   sess_type sess_ff;
   sess_type sess_in;
   rsp_type  rsp_ff;
   rsp_type  rsp_in;
   logic     rsp_valid_ff;
   logic     rsp_valid_in;
   logic     out_free;
   logic     advance;
   logic     req_take;

   fusc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   fusc_eval u_eval (
      .req (req_ff),
      .cur (sess_ff),
      .cfg (cfg),
      .nxt (sess_in),
      .rsp (rsp_in)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = req_valid_ff && out_free;
   assign req_stall = req_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign req_valid_in = req_take || (req_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sess_ff      <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            sess_ff <= sess_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff.mode            <= req_mode;
         req_ff.command_byte    <= req_command_byte;
         req_ff.sequence_number <= req_sequence_number;
         req_ff.payload_bytes   <= req_payload_bytes;
         req_ff.word_a          <= req_word_a;
         req_ff.word_b          <= req_word_b;
         req_ff.word_c          <= req_word_c;
         req_ff.word_d          <= req_word_d;
         req_ff.flash_ok        <= req_flash_ok;
         req_ff.check_ok        <= req_check_ok;
         req_ff.stored_version  <= req_stored_version;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_is_nack        = rsp_ff.is_nack;
   assign rsp_echo_sequence  = rsp_ff.echo_sequence;
   assign rsp_echo_command   = rsp_ff.echo_command;
   assign rsp_result_code    = rsp_ff.result_code;
   assign rsp_session_code   = rsp_ff.session_code;
   assign rsp_reply_value    = rsp_ff.reply_value;
   assign rsp_block_limit    = rsp_ff.block_limit;
   assign rsp_reboot_request = rsp_ff.reboot_request;

endmodule

### hw/rtl/fusc_csr.sv
module fusc_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata,
   output fusc_pkg::cfg_type cfg
);
   import fusc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_BOARD_MAGIC:     cfg_in.board_magic     = csr_wdata;
            CSR_MAX_BLOCK_BYTES: cfg_in.max_block_bytes = csr_wdata[15:0];
            CSR_MAX_IMAGE_BYTES: cfg_in.max_image_bytes = csr_wdata;
            CSR_LOADER_VERSION:  cfg_in.loader_version  = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.board_magic     <= BOARD_MAGIC_RESET;
         cfg_ff.max_block_bytes <= MAX_BLOCK_BYTES_RESET;
         cfg_ff.max_image_bytes <= MAX_IMAGE_BYTES_RESET;
         cfg_ff.loader_version  <= LOADER_VERSION_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hw/rtl/fusc_eval.sv
module fusc_eval (
   input  fusc_pkg::req_type  req,
   input  fusc_pkg::sess_type cur,
   input  fusc_pkg::cfg_type  cfg,
   output fusc_pkg::sess_type nxt,
   output fusc_pkg::rsp_type  rsp
);
   import fusc_pkg::*;

   logic [15:0] dl;
   logic [31:0] dl_wide;
   logic [31:0] data_end;
   logic [31:0] room;
   logic [15:0] expect_plen;
   logic        block_bad;
   logic [3:0]  res;
   logic [31:0] val;
   logic        reboot;

   assign dl          = req.word_b[15:0];
   assign dl_wide     = {16'd0, dl};
   assign data_end    = req.word_a + dl_wide;
   assign room        = cur.image_length - req.word_a;
   assign expect_plen = DATA_HEADER + dl;

   // A block must be nonzero, fit the limit, match the packet length, lie
   // inside the image, start word aligned, and be a whole number of words
   // unless it is the tail of the image.
   assign block_bad = (dl == 16'd0) || (dl > cfg.max_block_bytes) ||
                      (req.payload_bytes != expect_plen) ||
                      (req.word_a > cur.image_length) || (dl_wide > room) ||
                      ((req.word_a[1:0] & ALIGN_MASK) != 2'b00) ||
                      ((data_end < cur.image_length) && ((dl[1:0] & ALIGN_MASK) != 2'b00));

   always_comb begin
      nxt    = cur;
      res    = RES_OK;
      val    = 32'd0;
      reboot = 1'b0;
      case (req.mode)
         MODE_HELLO: val = cfg.loader_version;
         MODE_BEGIN: begin
            if (req.payload_bytes != BEGIN_PAYLOAD) begin
               res = RES_BAD_LENGTH;
            end else if (req.word_a != cfg.board_magic) begin
               res = RES_BAD_TARGET;
               val = req.word_a;
            end else if ((req.word_c == 32'd0) || (req.word_c > cfg.max_image_bytes)) begin
               res = RES_BAD_SIZE;
               val = req.word_c;
            end else begin
               nxt.next_offset = 32'd0;
               if (!req.flash_ok) begin
                  nxt.mode = SESS_ERROR;
                  res      = RES_ERASE_FAIL;
               end else begin
                  nxt.image_version  = req.word_b;
                  nxt.image_length   = req.word_c;
                  nxt.image_checksum = req.word_d;
                  nxt.mode           = SESS_RECV;
               end
            end
         end
         MODE_DATA: begin
            val = cur.next_offset;
            if (cur.mode != SESS_RECV) begin
               res = RES_NOT_STARTED;
            end else if (req.payload_bytes < DATA_MIN_PAYLOAD) begin
               res = RES_BAD_LENGTH;
            end else if (block_bad) begin
               res = RES_BAD_LENGTH;
            end else if (req.word_a == cur.next_offset) begin
               if (!req.flash_ok || !req.check_ok) begin
                  nxt.mode = SESS_ERROR;
                  res      = RES_WRITE_FAIL;
               end else begin
                  nxt.next_offset = cur.next_offset + dl_wide;
                  val             = cur.next_offset + dl_wide;
               end
            end else if (!((req.word_a < cur.next_offset) && (data_end <= cur.next_offset) &&
                           req.check_ok)) begin
               // A resent block already in flash is acked when it compares equal.
               res = RES_OFFSET_MISMATCH;
            end
         end
         MODE_END: begin
            if (req.payload_bytes != 16'd0) begin
               res = RES_BAD_LENGTH;
               val = cur.next_offset;
            end else if ((cur.mode != SESS_RECV) || (cur.next_offset != cur.image_length)) begin
               res = RES_OFFSET_MISMATCH;
               val = cur.next_offset;
            end else if (req.word_d != cur.image_checksum) begin
               nxt.mode = SESS_ERROR;
               res      = RES_CRC_FAIL;
               val      = req.word_d;
            end else if (!req.check_ok) begin
               nxt.mode = SESS_ERROR;
               res      = RES_INVALID;
            end else if (!req.flash_ok) begin
               nxt.mode = SESS_ERROR;
               res      = RES_WRITE_FAIL;
            end else begin
               nxt.mode = SESS_VERIFIED;
               val      = cur.image_length;
            end
         end
         MODE_INSTALL: begin
            if (req.payload_bytes != 16'd0) begin
               res = RES_BAD_LENGTH;
               val = cur.next_offset;
            end else if (!req.check_ok) begin
               res = RES_NO_IMAGE;
            end else if (!req.flash_ok) begin
               nxt.mode = SESS_ERROR;
               res      = RES_INSTALL_FAIL;
            end else begin
               nxt.mode = SESS_INSTALLED;
               val      = req.stored_version;
               reboot   = 1'b1;
            end
         end
         MODE_STATUS: val = cur.next_offset;
         MODE_ABORT: begin
            nxt.mode           = SESS_IDLE;
            nxt.image_version  = 32'd0;
            nxt.image_length   = 32'd0;
            nxt.image_checksum = 32'd0;
            nxt.next_offset    = 32'd0;
         end
         MODE_REBOOT: reboot = 1'b1;
         default: begin
            res = RES_UNKNOWN;
            val = cur.next_offset;
         end
      endcase

      rsp.is_nack        = (res != RES_OK);
      rsp.echo_sequence  = req.sequence_number;
      rsp.echo_command   = req.command_byte;
      rsp.result_code    = res;
      rsp.session_code   = nxt.mode;
      rsp.reply_value    = val;
      rsp.block_limit    = cfg.max_block_bytes;
      rsp.reboot_request = reboot;
   end

endmodule

### hw/rtl/fusc_checker.sv
module fusc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_is_nack,
   input logic [15:0] rsp_echo_sequence,
   input logic [3:0]  rsp_result_code,
   input logic [2:0]  rsp_session_code,
   input logic [31:0] rsp_reply_value,
   input logic        rsp_reboot_request
);
   import fusc_pkg::*;

   // A stalled reply transaction must hold.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_echo_sequence) &&
         $stable(rsp_result_code) && $stable(rsp_reply_value))
      else $error("reply changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("reply valid right after reset");

   a_nack_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_nack == (rsp_result_code != RES_OK)))
      else $error("nack flag disagrees with result code");

   // A reboot is only requested by an acked install or reboot command.
   a_reboot_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reboot_request |-> !rsp_is_nack)
      else $error("reboot requested on a failed transaction");

   a_codes_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_result_code <= RES_UNKNOWN) &&
         (rsp_session_code <= SESS_INSTALLED))
      else $error("reply code out of range");

endmodule

bind firmware_update_session_checker_unit fusc_checker u_fusc_checker (.*);

### bench/firmware_update_session_checker_unit_tb.sv
module firmware_update_session_checker_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fusc_pkg::*;

   // Mode values past reboot are all handled as unknown commands.
   localparam logic [3:0] MODE_UNKNOWN = 4'd8;
   localparam logic [3:0] MODE_TOP     = 4'd15;
   localparam int unsigned QUIET_LIMIT = 2000;
   localparam int unsigned REPORT_CAP  = 100;

   class session_scoreboard;
      logic [31:0] magic;
      logic [15:0] block_max;
      logic [31:0] image_max;
      logic [31:0] loader;
      logic [2:0]  sess;
      logic [31:0] img_version;
      logic [31:0] img_length;
      logic [31:0] img_crc;
      logic [31:0] next_off;
      rsp_type     replies_due[$];
      int unsigned fails;

      function new();
         magic       = BOARD_MAGIC_RESET;
         block_max   = MAX_BLOCK_BYTES_RESET;
         image_max   = MAX_IMAGE_BYTES_RESET;
         loader      = LOADER_VERSION_RESET;
         fails       = 0;
         clear_session();
      endfunction

      function void clear_session();
         sess        = SESS_IDLE;
         img_version = '0;
         img_length  = '0;
         img_crc     = '0;
         next_off    = '0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [31:0] data);
         case (idx)
            CSR_BOARD_MAGIC:     magic = data;
            CSR_MAX_BLOCK_BYTES: block_max = data[15:0];
            CSR_MAX_IMAGE_BYTES: image_max = data;
            CSR_LOADER_VERSION:  loader = data;
            default: ;
         endcase
      endfunction

      function int unsigned outstanding();
         return replies_due.size();
      endfunction

      // Works out the reply to one accepted request transaction and moves the
      // session state on, in the order the block sees the requests.
      function void note_request(req_type r);
         logic [3:0]  res;
         logic [31:0] val;
         logic        boot;
         logic [31:0] blk;
         logic [15:0] framed;
         rsp_type     want;
         res    = RES_OK;
         val    = '0;
         boot   = 1'b0;
         blk    = {16'd0, r.word_b[15:0]};
         framed = DATA_HEADER + r.word_b[15:0];
         case (r.mode)
            MODE_HELLO: begin
               val = loader;
            end
            MODE_BEGIN: begin
               if (r.payload_bytes != BEGIN_PAYLOAD) begin
                  res = RES_BAD_LENGTH;
               end else if (r.word_a != magic) begin
                  res = RES_BAD_TARGET;
                  val = r.word_a;
               end else if (r.word_c == 0 || r.word_c > image_max) begin
                  res = RES_BAD_SIZE;
                  val = r.word_c;
               end else begin
                  next_off = '0;
                  if (!r.flash_ok) begin
                     sess = SESS_ERROR;
                     res  = RES_ERASE_FAIL;
                  end else begin
                     img_version = r.word_b;
                     img_length  = r.word_c;
                     img_crc     = r.word_d;
                     sess        = SESS_RECV;
                  end
               end
            end
            MODE_DATA: begin
               val = next_off;
               if (sess != SESS_RECV) begin
                  res = RES_NOT_STARTED;
               end else if (r.payload_bytes < DATA_MIN_PAYLOAD) begin
                  res = RES_BAD_LENGTH;
               end else if (blk == 0 || blk > {16'd0, block_max} ||
                            r.payload_bytes != framed ||
                            r.word_a > img_length || blk > img_length - r.word_a ||
                            (r.word_a[1:0] & ALIGN_MASK) != 2'b00 ||
                            (r.word_a + blk < img_length &&
                             (blk[1:0] & ALIGN_MASK) != 2'b00)) begin
                  res = RES_BAD_LENGTH;
               end else if (r.word_a == next_off) begin
                  if (!r.flash_ok || !r.check_ok) begin
                     sess = SESS_ERROR;
                     res  = RES_WRITE_FAIL;
                  end else begin
                     next_off = next_off + blk;
                     val      = next_off;
                  end
               end else if (!(r.word_a < next_off && r.word_a + blk <= next_off &&
                              r.check_ok)) begin
                  // A resend of an already written block passes only when the
                  // flash compare says it matches.
                  res = RES_OFFSET_MISMATCH;
               end
            end
            MODE_END: begin
               if (r.payload_bytes != 0) begin
                  res = RES_BAD_LENGTH;
                  val = next_off;
               end else if (sess != SESS_RECV || next_off != img_length) begin
                  res = RES_OFFSET_MISMATCH;
                  val = next_off;
               end else if (r.word_d != img_crc) begin
                  sess = SESS_ERROR;
                  res  = RES_CRC_FAIL;
                  val  = r.word_d;
               end else if (!r.check_ok) begin
                  sess = SESS_ERROR;
                  res  = RES_INVALID;
               end else if (!r.flash_ok) begin
                  sess = SESS_ERROR;
                  res  = RES_WRITE_FAIL;
               end else begin
                  sess = SESS_VERIFIED;
                  val  = img_length;
               end
            end
            MODE_INSTALL: begin
               if (r.payload_bytes != 0) begin
                  res = RES_BAD_LENGTH;
                  val = next_off;
               end else if (!r.check_ok) begin
                  res = RES_NO_IMAGE;
               end else if (!r.flash_ok) begin
                  sess = SESS_ERROR;
                  res  = RES_INSTALL_FAIL;
               end else begin
                  sess = SESS_INSTALLED;
                  val  = r.stored_version;
                  boot = 1'b1;
               end
            end
            MODE_STATUS: begin
               val = next_off;
            end
            MODE_ABORT: begin
               clear_session();
            end
            MODE_REBOOT: begin
               boot = 1'b1;
            end
            default: begin
               res = RES_UNKNOWN;
               val = next_off;
            end
         endcase
         want.is_nack        = (res != RES_OK);
         want.echo_sequence  = r.sequence_number;
         want.echo_command   = r.command_byte;
         want.result_code    = res;
         want.session_code   = sess;
         want.reply_value    = val;
         want.block_limit    = block_max;
         want.reboot_request = boot;
         replies_due.push_back(want);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            fails++;
            if (fails <= REPORT_CAP)
               $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         end
      endfunction

      function void check_reply(rsp_type got);
         rsp_type want;
         if (replies_due.size() == 0) begin
            fails++;
            if (fails <= REPORT_CAP)
               $error("reply with sequence 0x%0h arrived with no request outstanding",
                      got.echo_sequence);
            return;
         end
         want = replies_due.pop_front();
         compare_field("is_nack", want.is_nack, got.is_nack);
         compare_field("echo_sequence", want.echo_sequence, got.echo_sequence);
         compare_field("echo_command", want.echo_command, got.echo_command);
         compare_field("result_code", want.result_code, got.result_code);
         compare_field("session_code", want.session_code, got.session_code);
         compare_field("reply_value", want.reply_value, got.reply_value);
         compare_field("block_limit", want.block_limit, got.block_limit);
         compare_field("reboot_request", want.reboot_request, got.reboot_request);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_bus = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_is_nack;
   logic [15:0] rsp_echo_sequence;
   logic [7:0]  rsp_echo_command;
   logic [3:0]  rsp_result_code;
   logic [2:0]  rsp_session_code;
   logic [31:0] rsp_reply_value;
   logic [15:0] rsp_block_limit;
   logic        rsp_reboot_request;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = CSR_BOARD_MAGIC;
   logic [31:0] csr_wdata = '0;

   session_scoreboard sb = new();

   int unsigned items_sent = 0;
   int unsigned burst_left = 0;
   int unsigned quiet_cycles = 0;
   int unsigned stall_style = 0;
   int unsigned style_left = 0;

   firmware_update_session_checker_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_mode            (req_bus.mode),
      .req_command_byte    (req_bus.command_byte),
      .req_sequence_number (req_bus.sequence_number),
      .req_payload_bytes   (req_bus.payload_bytes),
      .req_word_a          (req_bus.word_a),
      .req_word_b          (req_bus.word_b),
      .req_word_c          (req_bus.word_c),
      .req_word_d          (req_bus.word_d),
      .req_flash_ok        (req_bus.flash_ok),
      .req_check_ok        (req_bus.check_ok),
      .req_stored_version  (req_bus.stored_version),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_is_nack         (rsp_is_nack),
      .rsp_echo_sequence   (rsp_echo_sequence),
      .rsp_echo_command    (rsp_echo_command),
      .rsp_result_code     (rsp_result_code),
      .rsp_session_code    (rsp_session_code),
      .rsp_reply_value     (rsp_reply_value),
      .rsp_block_limit     (rsp_block_limit),
      .rsp_reboot_request  (rsp_reboot_request),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_type got;
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_request(req_bus);
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_is_nack, rsp_echo_sequence, rsp_echo_command, rsp_result_code,
                   rsp_session_code, rsp_reply_value, rsp_block_limit,
                   rsp_reboot_request};
            sb.check_reply(got);
         end
      end
   end

   // The receiver switches between no stalls, light and heavy random stalls,
   // and a fixed periodic stall.
   always @(posedge clock) begin
      if (style_left == 0) begin
         stall_style = $urandom_range(0, 3);
         style_left  = $urandom_range(20, 150);
      end
      style_left--;
      case (stall_style)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 4) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= ((style_left % 11) < 4);
      endcase
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("firmware_update_session_checker_unit: mismatch");
         $finish;
      end
   end

   function automatic req_type build_req(logic [3:0] mode, logic [15:0] plen,
                                         logic [31:0] a, b, c, d, logic fok, cok);
      req_type r;
      r.mode            = mode;
      r.command_byte    = 8'($urandom);
      r.sequence_number = 16'($urandom);
      r.payload_bytes   = plen;
      r.word_a          = a;
      r.word_b          = b;
      r.word_c          = c;
      r.word_d          = d;
      r.flash_ok        = fok;
      r.check_ok        = cok;
      r.stored_version  = $urandom;
      return r;
   endfunction

   function automatic req_type data_req(logic [31:0] off, logic [31:0] len,
                                        logic fok, cok);
      return build_req(MODE_DATA, 16'(DATA_HEADER + len[15:0]), off,
                       {16'($urandom), len[15:0]}, $urandom, $urandom, fok, cok);
   endfunction

   function automatic req_type noise_req();
      return build_req(4'($urandom), 16'($urandom), $urandom, $urandom, $urandom,
                       $urandom, 1'($urandom), 1'($urandom));
   endfunction

   // The sender works in bursts; between bursts it may drop valid for a random gap.
   task automatic send_item(input req_type r);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                   : $urandom_range(1, 8);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_bus   <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic drain_replies();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   task automatic load_config(input logic [31:0] magic, input logic [15:0] block,
                              input logic [31:0] image, input logic [31:0] loader);
      write_reg(CSR_BOARD_MAGIC, magic);
      write_reg(CSR_MAX_BLOCK_BYTES, {16'd0, block});
      write_reg(CSR_MAX_IMAGE_BYTES, image);
      write_reg(CSR_LOADER_VERSION, loader);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   // One update session: begin, data blocks in order, end, install, with
   // occasional faults and stray commands mixed in.
   task automatic run_session();
      logic [31:0] size, lim, ver, crc, off, len, cap, rem, prev_off, prev_len;
      logic [31:0] bad;
      int unsigned pick, v;
      logic        began;
      lim  = (sb.image_max == 0) ? 32'd1 : ((sb.image_max < 160) ? sb.image_max : 32'd160);
      size = $urandom_range(1, lim);
      ver  = $urandom;
      crc  = $urandom;
      began = 1'b0;
      pick = $urandom_range(0, 19);
      case (pick)
         0: send_item(build_req(MODE_BEGIN, 16'($urandom_range(0, 15)), sb.magic, ver,
                                size, crc, 1'b1, 1'b1));
         1: send_item(build_req(MODE_BEGIN, BEGIN_PAYLOAD,
                                sb.magic ^ (32'd1 << $urandom_range(0, 31)), ver, size,
                                crc, 1'b1, 1'b1));
         2: begin
            bad = ($urandom_range(0, 1) == 0 || sb.image_max == '1) ? 32'd0
                                                                    : sb.image_max + 1;
            send_item(build_req(MODE_BEGIN, BEGIN_PAYLOAD, sb.magic, ver, bad, crc,
                                1'b1, 1'b1));
         end
         3: send_item(build_req(MODE_BEGIN, BEGIN_PAYLOAD, sb.magic, ver, size, crc,
                                1'b0, 1'($urandom)));
         default: begin
            send_item(build_req(MODE_BEGIN, BEGIN_PAYLOAD, sb.magic, ver, size, crc,
                                1'b1, 1'($urandom)));
            began = 1'b1;
         end
      endcase
      if (!began && $urandom_range(0, 1) == 0)
         return;
      off      = '0;
      prev_off = '0;
      prev_len = '0;
      while (off < size) begin
         rem = size - off;
         cap = (sb.block_max < 16'd64) ? {16'd0, sb.block_max} : 32'd64;
         if (rem <= cap) begin
            len = rem;
         end else if (cap < 4) begin
            // No aligned block fits; this one is rejected and the session stalls.
            send_item(data_req(off, cap, 1'b1, 1'b1));
            break;
         end else begin
            len = 4 * $urandom_range(1, cap / 4);
         end
         pick = $urandom_range(0, 39);
         case (pick)
            0: send_item(build_req(($urandom_range(0, 1) == 0) ? MODE_STATUS : MODE_HELLO,
                                   16'($urandom), $urandom, $urandom, $urandom, $urandom,
                                   1'($urandom), 1'($urandom)));
            1: send_item(data_req(off + $urandom_range(1, 3), len, 1'b1, 1'b1));
            2: send_item(build_req(MODE_DATA, 16'(DATA_HEADER + len[15:0] + 1), off,
                                   {16'($urandom), len[15:0]}, $urandom, $urandom,
                                   1'b1, 1'b1));
            3: begin
               v = $urandom_range(0, 2);
               send_item(data_req(off, len, v[0], v[1]));
               break;
            end
            4: send_item(data_req(off + 4 * $urandom_range(1, 4), len, 1'b1, 1'b1));
            5: if (off != 0)
                  send_item(data_req(prev_off, prev_len, 1'b1, 1'($urandom)));
            6: if (sb.block_max != 16'hFFFF)
                  send_item(data_req(off, {16'd0, sb.block_max} + 1, 1'b1, 1'b1));
            default: ;
         endcase
         send_item(data_req(off, len, 1'b1, 1'b1));
         prev_off = off;
         prev_len = len;
         off      = off + len;
      end
      send_item(build_req(MODE_END,
                          ($urandom_range(0, 19) == 0) ? 16'($urandom_range(1, 65535)) : 16'd0,
                          $urandom, $urandom, $urandom,
                          ($urandom_range(0, 11) == 0) ? crc ^ (32'd1 << $urandom_range(0, 31))
                                                       : crc,
                          ($urandom_range(0, 14) != 0), ($urandom_range(0, 14) != 0)));
      if ($urandom_range(0, 4) != 0)
         send_item(build_req(MODE_INSTALL,
                             ($urandom_range(0, 19) == 0) ? 16'($urandom_range(1, 65535))
                                                          : 16'd0,
                             $urandom, $urandom, $urandom, $urandom,
                             ($urandom_range(0, 9) != 0), ($urandom_range(0, 9) != 0)));
      case ($urandom_range(0, 5))
         0: send_item(build_req(MODE_REBOOT, 16'($urandom), $urandom, $urandom, $urandom,
                                $urandom, 1'($urandom), 1'($urandom)));
         1: send_item(build_req(MODE_ABORT, 16'($urandom), $urandom, $urandom, $urandom,
                                $urandom, 1'($urandom), 1'($urandom)));
         2: send_item(build_req(MODE_STATUS, 16'($urandom), $urandom, $urandom, $urandom,
                                $urandom, 1'($urandom), 1'($urandom)));
         default: ;
      endcase
   endtask

   task automatic random_traffic(input int unsigned count);
      int unsigned start;
      start = items_sent;
      while (items_sent - start < count) begin
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) send_item(noise_req());
         else
            run_session();
         if ($urandom_range(0, 29) == 0)
            drain_replies();
      end
   endtask

   localparam logic [31:0] DIR_MAGIC = 32'hA5C3_1F07;
   localparam logic [31:0] DIR_VER   = 32'h0102_0304;
   localparam logic [31:0] DIR_CRC   = 32'hC0FF_EE11;

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Register defaults first.
      random_traffic(60);
      drain_replies();

      load_config(DIR_MAGIC, 16'd16, 32'd64, 32'hFFFF_FFFF);
      send_item(build_req(MODE_HELLO, 16'd0, '0, '0, '0, '0, 1'b1, 1'b1));
      send_item(build_req(MODE_STATUS, 16'd0, '0, '0, '0, '0, 1'b1, 1'b1));
      send_item(build_req(MODE_UNKNOWN, 16'd0, '0, '0, '0, '0, 1'b1, 1'b1));
      send_item(build_req(MODE_TOP, 16'hFFFF, '1, '1, '1, '1, 1'b1, 1'b1));
      send_item(data_req(32'd0, 32'd4, 1'b1, 1'b1));
      send_item(build_req(MODE_END, 16'd0, '0, '0, '0, DIR_CRC, 1'b1, 1'b1));
      send_item(build_req(MODE_BEGIN, 16'd15, DIR_MAGIC, DIR_VER, 32'd10, DIR_CRC,
                          1'b1, 1'b1));
      send_item(build_req(MODE_BEGIN, BEGIN_PAYLOAD, DIR_MAGIC ^ 32'h8000_0000, DIR_VER,
                          32'd10, DIR_CRC, 1'b1, 1'b1));
      send_item(build_req(MODE_BEGIN, BEGIN_PAYLOAD, DIR_MAGIC, DIR_VER, 32'd0, DIR_CRC,
                          1'b1, 1'b1));
      send_item(build_req(MODE_BEGIN, BEGIN_PAYLOAD, DIR_MAGIC, DIR_VER, 32'd65, DIR_CRC,
                          1'b1, 1'b1));
      send_item(build_req(MODE_BEGIN, BEGIN_PAYLOAD, DIR_MAGIC, DIR_VER, 32'd10, DIR_CRC,
                          1'b0, 1'b1));
      send_item(build_req(MODE_BEGIN, BEGIN_PAYLOAD, DIR_MAGIC, DIR_VER, 32'd10, DIR_CRC,
                          1'b1, 1'b1));
      send_item(build_req(MODE_DATA, 16'd6, 32'd0, 32'd4, '0, '0, 1'b1, 1'b1));
      send_item(data_req(32'd0, 32'd4, 1'b1, 1'b1));
      send_item(data_req(32'd2, 32'd4, 1'b1, 1'b1));
      // Resent first block: accepted when the compare matches, refused otherwise.
      send_item(data_req(32'd0, 32'd4, 1'b1, 1'b1));
      send_item(data_req(32'd0, 32'd4, 1'b1, 1'b0));
      send_item(data_req(32'd8, 32'd2, 1'b1, 1'b1));
      send_item(data_req(32'd4, 32'd17, 1'b1, 1'b1));
      // The last block may have a length that is not a multiple of four.
      send_item(data_req(32'd4, 32'd6, 1'b1, 1'b1));
      send_item(build_req(MODE_END, 16'd4, '0, '0, '0, DIR_CRC, 1'b1, 1'b1));
      send_item(build_req(MODE_END, 16'd0, '0, '0, '0, DIR_CRC, 1'b1, 1'b1));
      send_item(build_req(MODE_INSTALL, 16'd0, '0, '0, '0, '0, 1'b1, 1'b0));
      send_item(build_req(MODE_INSTALL, 16'd0, '0, '0, '0, '0, 1'b1, 1'b1));
      send_item(build_req(MODE_REBOOT, 16'd0, '0, '0, '0, '0, 1'b1, 1'b1));
      send_item(build_req(MODE_ABORT, 16'd0, '0, '0, '0, '0, 1'b1, 1'b1));
      drain_replies();

      load_config($urandom, 16'd32, 32'd160, $urandom);
      random_traffic(250);
      drain_replies();

      load_config('1, 16'hFFFF, '1, '0);
      random_traffic(250);
      drain_replies();

      // A zero block limit turns every data transaction of a session away.
      load_config('0, 16'd0, 32'd100, 32'h1234_5678);
      random_traffic(120);
      drain_replies();

      load_config($urandom, 16'd1, 32'd1, $urandom);
      random_traffic(150);
      drain_replies();

      load_config($urandom, 16'd4, 32'd0, $urandom);
      random_traffic(80);
      drain_replies();

      load_config($urandom, 16'($urandom_range(1, 80)), $urandom_range(1, 300), $urandom);
      random_traffic(300);
      drain_replies();

      repeat (20) @(posedge clock);
      if (sb.fails == 0)
         $display("firmware_update_session_checker_unit: match");
      else
         $display("firmware_update_session_checker_unit: mismatch");
      $finish;
   end

endmodule
